// ===== hdl/matrix_inverse_4x4_unit_assert.svh =====
// Assertion macros for the 4x4 matrix inverse unit.
// Included by the top level; depends on nothing else.
`ifndef MATRIX_INVERSE_4X4_UNIT_ASSERT_SVH
`define MATRIX_INVERSE_4X4_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MI4_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mi4 assertion failed");
`define MI4_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mi4 assertion failed");
`else
`define MI4_ASSERT(label, clk, rst, prop)
`define MI4_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hdl/mi4_pkg.sv =====
// Package for the 4x4 matrix inverse unit: beat types, fixed widths, helpers.
// No dependencies.
`default_nettype none
package mi4_pkg;

  localparam int VALUE_W = 32;
  localparam int COF_W   = 64;
  localparam int WIDE_W  = 128;

  typedef struct packed {
    logic [3:0]                elem_index;
    logic signed [VALUE_W-1:0] elem_value;
    logic                      last_elem;
  } elem_beat_t;

  typedef struct packed {
    logic [3:0]                out_index;
    logic signed [VALUE_W-1:0] out_value;
    logic                      singular;
    logic                      last_out;
  } res_beat_t;

  // Saturate a 128-bit signed value to 64 bits signed.
  function automatic logic [COF_W-1:0] sat64(input logic [WIDE_W-1:0] a);
    logic fits;
    fits = (a[WIDE_W-1:COF_W-1] == {(WIDE_W-COF_W+1){1'b0}}) ||
           (a[WIDE_W-1:COF_W-1] == {(WIDE_W-COF_W+1){1'b1}});
    if (fits) return a[COF_W-1:0];
    else if (a[WIDE_W-1]) return {1'b1, {(COF_W-1){1'b0}}};
    else return {1'b0, {(COF_W-1){1'b1}}};
  endfunction

  // Matrix address of factor f of term k of the 3x3 minor for adjugate position p.
  function automatic logic [3:0] minor_addr(input logic [3:0] p, input logic [2:0] k,
                                            input logic [1:0] f);
    logic [11:0] tr;
    logic [3:0]  e;
    logic [1:0]  i;
    logic [1:0]  j;
    logic [1:0]  row;
    logic [1:0]  col;
    case (k)
      3'd0:    tr = 12'h048;
      3'd1:    tr = 12'h156;
      3'd2:    tr = 12'h237;
      3'd3:    tr = 12'h246;
      3'd4:    tr = 12'h138;
      3'd5:    tr = 12'h057;
      default: tr = 12'h048;
    endcase
    case (f)
      2'd0:    e = tr[11:8];
      2'd1:    e = tr[7:4];
      default: e = tr[3:0];
    endcase
    i = (e >= 4'd6) ? 2'd2 : ((e >= 4'd3) ? 2'd1 : 2'd0);
    j = 2'(e - 4'({2'b00, i}) * 4'd3);
    row = (i < p[3:2]) ? i : i + 2'd1;
    col = (j < p[1:0]) ? j : j + 2'd1;
    return {col, row};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/matrix_inverse_4x4_unit.sv =====
// 4x4 matrix inverse by adjugate and determinant, Q16.16-style fixed point.
// Depends on mi4_pkg, mi4_ram and matrix_inverse_4x4_unit_assert.svh.
//
//   channel | signals                   | beat
//   --------+---------------------------+--------------------------------------
//   elem    | elem_valid, elem_ready    | one matrix element, column-major
//   res     | res_valid, res_ready      | one inverse element or singular flag
//
// A non-last element is stored while elem_ready is high. The last element starts a
// run on one shared multiplier (four 32x32 partial products per product): 16
// cofactors x 6 terms x 2 products, then 4 determinant products and a check for
// a zero determinant, then 16 restoring divisions of 64+FRAC_BITS steps, one per
// result. Output stalls lengthen a run; a singular matrix ends after the check.
// Reset is synchronous; it clears the sequencer only. The stores need no clear.
// elem_ready is low for the whole run; a stalled result holds the sequencer.
`default_nettype none
`include "matrix_inverse_4x4_unit_assert.svh"
module matrix_inverse_4x4_unit
  import mi4_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       elem_valid,
  output logic            elem_ready,
  input  wire elem_beat_t elem,
  output logic            res_valid,
  input  wire logic       res_ready,
  output res_beat_t       res
);
  localparam int NUMW = COF_W + FRAC_BITS;
  localparam int DCW  = $clog2(NUMW);
  localparam logic [NUMW-1:0] MAXQ = {{(NUMW-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};

  localparam logic [4:0] S_IDLE = 5'd0,  S_RX   = 5'd1,  S_LX   = 5'd2,  S_LY  = 5'd3,
                         S_MABS = 5'd4,  S_MUL  = 5'd5,  S_MSGN = 5'd6,  S_T   = 5'd7,
                         S_LZ   = 5'd8,  S_ACC  = 5'd9,  S_COF  = 5'd10, S_DRD = 5'd11,
                         S_DLD  = 5'd12, S_DACC = 5'd13, S_CHK  = 5'd14, S_QRD = 5'd15,
                         S_QLD  = 5'd16, S_DIV  = 5'd17, S_RES  = 5'd18, S_OUT = 5'd19;

  logic [4:0] state, state_next, mret;
  logic [3:0] p;
  logic [2:0] k;
  logic [1:0] mcnt;
  logic [DCW-1:0] dcnt;

  logic signed [COF_W-1:0]  opa, opb;
  logic [COF_W-1:0]         amag, bmag;
  logic                     msgn;
  logic [WIDE_W-1:0]        acc;
  logic signed [WIDE_W-1:0] prod, sum, det;
  logic [WIDE_W-1:0]        dmag;
  logic                     dneg, qneg;
  logic [WIDE_W-1:0]        rem;
  logic [NUMW-1:0]          dq;

  logic                     mat_we;
  logic [3:0]               mat_raddr, cof_raddr;
  logic [VALUE_W-1:0]       mat_rdata;
  logic [COF_W-1:0]         cof_rdata, cof_wdata;
  logic                     cof_we;

  logic signed [COF_W-1:0]  mat_sx;
  logic signed [WIDE_W-1:0] prod_sh, sum_fix;
  logic [COF_W-1:0]         pp;
  logic [WIDE_W-1:0]        pp_sh;
  logic [WIDE_W:0]          rem_sh;
  logic                     ge;
  logic signed [NUMW-1:0]   num;
  logic [VALUE_W-1:0]       qres;

  assign elem_ready = (state == S_IDLE);
  assign res_valid  = (state == S_OUT);
  assign mat_we     = elem_valid && elem_ready;

  mi4_ram #(.WIDTH(VALUE_W), .DEPTH(16)) u_mat (
    .clk(clk), .we(mat_we), .waddr(elem.elem_index), .wdata(elem.elem_value),
    .raddr(mat_raddr), .rdata(mat_rdata));

  mi4_ram #(.WIDTH(COF_W), .DEPTH(16)) u_cof (
    .clk(clk), .we(cof_we), .waddr(p), .wdata(cof_wdata),
    .raddr(cof_raddr), .rdata(cof_rdata));

  // Pick the read address for the element the next state loads.
  always_comb begin
    unique case (state)
      S_RX:    mat_raddr = minor_addr(p, k, 2'd0);
      S_LX:    mat_raddr = minor_addr(p, k, 2'd1);
      S_T:     mat_raddr = minor_addr(p, k, 2'd2);
      S_DRD:   mat_raddr = {2'b00, p[1:0]};
      default: mat_raddr = 4'd0;
    endcase
    cof_raddr = (state == S_DRD) ? {p[1:0], 2'b00} : p;
  end

  always_comb begin
    mat_sx  = {{(COF_W-VALUE_W){mat_rdata[VALUE_W-1]}}, mat_rdata};
    prod_sh = prod >>> FRAC_BITS;
    // Cofactor sign follows the parity of row plus column.
    sum_fix   = (p[0] ^ p[2]) ? -sum : sum;
    cof_wdata = sat64(sum_fix);
    cof_we    = (state == S_COF);
    pp = COF_W'(amag[mcnt[1]*32 +: 32]) * COF_W'(bmag[mcnt[0]*32 +: 32]);
    case (mcnt)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    rem_sh = {rem, dq[NUMW-1]};
    ge     = rem_sh >= {1'b0, dmag};
    num    = {cof_rdata, {FRAC_BITS{1'b0}}};
    // Saturate the quotient magnitude to the signed result range.
    if (qneg) begin
      qres = (dq > MAXQ + NUMW'(1)) ? {1'b1, {(VALUE_W-1){1'b0}}} : -dq[VALUE_W-1:0];
    end else begin
      qres = (dq > MAXQ) ? MAXQ[VALUE_W-1:0] : dq[VALUE_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (mat_we && elem.last_elem) state_next = S_RX;
      S_RX:    state_next = S_LX;
      S_LX:    state_next = S_LY;
      S_LY:    state_next = S_MABS;
      S_MABS:  state_next = S_MUL;
      S_MUL:   if (mcnt == 2'd3) state_next = S_MSGN;
      S_MSGN:  state_next = mret;
      S_T:     state_next = S_LZ;
      S_LZ:    state_next = S_MABS;
      S_ACC:   state_next = (k == 3'd5) ? S_COF : S_RX;
      S_COF:   state_next = (p == 4'd15) ? S_DRD : S_RX;
      S_DRD:   state_next = S_DLD;
      S_DLD:   state_next = S_MABS;
      S_DACC:  state_next = (p[1:0] == 2'd3) ? S_CHK : S_DRD;
      S_CHK:   state_next = (det == '0) ? S_OUT : S_QRD;
      S_QRD:   state_next = S_QLD;
      S_QLD:   state_next = S_DIV;
      S_DIV:   if (dcnt == DCW'(NUMW-1)) state_next = S_RES;
      S_RES:   state_next = S_OUT;
      S_OUT:   if (res_ready) state_next = res.last_out ? S_IDLE : S_QRD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers; the sequencer state gates them, and res_ready also gates the index step in S_OUT.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        p   <= 4'd0;
        k   <= 3'd0;
        sum <= '0;
      end
      S_LX:   opa <= mat_sx;
      S_LY: begin
        opb  <= mat_sx;
        mret <= S_T;
      end
      S_MABS: begin
        amag <= opa[COF_W-1] ? -opa : opa;
        bmag <= opb[COF_W-1] ? -opb : opb;
        msgn <= opa[COF_W-1] ^ opb[COF_W-1];
        acc  <= '0;
        mcnt <= 2'd0;
      end
      S_MUL: begin
        acc  <= acc + pp_sh;
        mcnt <= mcnt + 2'd1;
      end
      S_MSGN: prod <= msgn ? -acc : acc;
      S_T:    opa <= sat64(prod_sh);
      S_LZ: begin
        opb  <= mat_sx;
        mret <= S_ACC;
      end
      S_ACC: begin
        sum <= (k < 3'd3) ? sum + prod_sh : sum - prod_sh;
        k   <= k + 3'd1;
      end
      S_COF: begin
        sum <= '0;
        k   <= 3'd0;
        p   <= p + 4'd1;
        det <= '0;
      end
      S_DLD: begin
        opa  <= mat_sx;
        opb  <= cof_rdata;
        mret <= S_DACC;
      end
      S_DACC: begin
        det <= det + prod_sh;
        p   <= (p[1:0] == 2'd3) ? 4'd0 : p + 4'd1;
      end
      S_CHK: begin
        dmag <= det[WIDE_W-1] ? -det : det;
        dneg <= det[WIDE_W-1];
        res  <= '{out_index: 4'd0, out_value: '0, singular: 1'b1, last_out: 1'b1};
      end
      S_QLD: begin
        qneg <= num[NUMW-1] ^ dneg;
        dq   <= num[NUMW-1] ? -num : num;
        rem  <= '0;
        dcnt <= '0;
      end
      S_DIV: begin
        rem  <= ge ? WIDE_W'(rem_sh - {1'b0, dmag}) : rem_sh[WIDE_W-1:0];
        dq   <= {dq[NUMW-2:0], ge};
        dcnt <= dcnt + DCW'(1);
      end
      S_RES: begin
        res <= '{out_index: p, out_value: qres, singular: 1'b0, last_out: (p == 4'd15)};
      end
      S_OUT:  if (res_ready) p <= p + 4'd1;
      default: ;
    endcase
  end

  `MI4_ASSERT(a_ready_excl_valid, clk, rst, !(elem_ready && res_valid))
  `MI4_ASSERT(a_singular_form, clk, rst,
              (res_valid && res.singular) |-> (res.last_out && res.out_index == 4'd0))
  `MI4_ASSERT(a_last_starts_run, clk, rst,
              (elem_valid && elem_ready && elem.last_elem) |=> !elem_ready)
  `MI4_ASSERT(a_div_bound, clk, rst, (state == S_DIV) |-> (dcnt <= DCW'(NUMW-1)))
  `MI4_ASSERT(a_last_index, clk, rst,
              (res_valid && !res.singular && res.last_out) |-> (res.out_index == 4'd15))
endmodule
`default_nettype wire

// ===== hdl/mi4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
